// ===== rtl/sha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Shared types, round constants and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int BLK_BYTES    = 64;
  localparam int BLK_BITS     = BLK_BYTES * 8;
  localparam int BLK_WORDS    = BLK_BYTES / 4;
  localparam int ROUNDS       = 64;
  localparam int DIGEST_WORDS = 8;
  localparam int POS_W        = $clog2(BLK_BYTES);
  localparam int BYTE_CNT_W   = 61;
  localparam int Q_DEPTH      = 2;
  localparam int Q_AW         = $clog2(Q_DEPTH);

  localparam logic       OP_ABSORB   = 1'b0;
  localparam logic       OP_FINISH   = 1'b1;
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [POS_W-1:0] LEN_POS = POS_W'(56);

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } sha_out_t;

  typedef struct packed {
    logic                last_blk;
    logic [BLK_BITS-1:0] data;
  } sha_blk_t;

  typedef enum logic {
    FR_FILL,
    FR_PAD2
  } fr_state_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_ADD
  } core_state_t;

  localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                     input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== rtl/sha_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 front end
// Collects message bytes into a block, applies padding on finish and hands
// complete blocks to the block queue.
// ----------------------------------------------------------------------------
module sha_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sha_pkg::sha_in_t in_data,
  output logic             full,
  output logic             q_push,
  output sha_pkg::sha_blk_t q_blk,
  input  logic             q_full
);
  import sha_pkg::*;

  fr_state_t             state_r, state_nxt;
  logic [BYTE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BLK_BITS-1:0]   blk_r, blk_nxt;
  logic [BLK_BITS-1:0]   pad_blk;
  logic [POS_W-1:0]      pos;
  logic [63:0]           len_bits;
  logic                  accept;

  assign pos      = cnt_r[POS_W-1:0];
  assign len_bits = {cnt_r, 3'b000};
  assign full     = q_full || (state_r == FR_PAD2);
  assign accept   = push && !full;

  // Bytes already written stay, the pad marker goes at the current position
  // and everything after it reads as zero.
  always_comb begin
    for (int j = 0; j < BLK_BYTES; j++) begin
      if (POS_W'(j) < pos) begin
        pad_blk[BLK_BITS-1-8*j -: 8] = blk_r[BLK_BITS-1-8*j -: 8];
      end else if (POS_W'(j) == pos) begin
        pad_blk[BLK_BITS-1-8*j -: 8] = PAD_BYTE;
      end else begin
        pad_blk[BLK_BITS-1-8*j -: 8] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_FILL;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    blk_nxt        = blk_r;
    q_push         = 1'b0;
    q_blk.last_blk = 1'b0;
    q_blk.data     = pad_blk;
    unique case (state_r)
      FR_FILL: begin
        if (accept) begin
          if (in_data.op == OP_ABSORB) begin
            blk_nxt[{~pos, 3'b111} -: 8] = in_data.data_byte;
            cnt_nxt = cnt_r + BYTE_CNT_W'(1);
            if (pos == POS_W'(BLK_BYTES - 1)) begin
              q_push     = 1'b1;
              q_blk.data = {blk_r[BLK_BITS-1:8], in_data.data_byte};
            end
          end else begin
            q_push = 1'b1;
            if (pos < LEN_POS) begin
              q_blk.last_blk = 1'b1;
              q_blk.data     = {pad_blk[BLK_BITS-1:64], len_bits};
              cnt_nxt        = '0;
            end else begin
              state_nxt = FR_PAD2;
            end
          end
        end
      end
      FR_PAD2: begin
        // The length did not fit; it goes alone into one more block.
        if (!q_full) begin
          q_push         = 1'b1;
          q_blk.last_blk = 1'b1;
          q_blk.data     = {{(BLK_BITS-64){1'b0}}, len_bits};
          cnt_nxt        = '0;
          state_nxt      = FR_FILL;
        end
      end
      default: state_nxt = FR_FILL;
    endcase
  end

endmodule

// ===== rtl/sha_blk_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 block queue
// Short register queue of padded or complete blocks between front and core.
// ----------------------------------------------------------------------------
module sha_blk_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  sha_pkg::sha_blk_t wr_data,
  output logic              full_o,
  input  logic              pop_i,
  output sha_pkg::sha_blk_t rd_data,
  output logic              empty_o
);
  import sha_pkg::*;

  sha_blk_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + (Q_AW+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (Q_AW+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("block pushed into a full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("block queue count out of range");

endmodule

// ===== rtl/sha_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs one round per cycle on queued blocks and presents the digest words.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  sha_pkg::sha_blk_t q_blk,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  core_state_t      st_r, st_nxt;
  logic [POS_W-1:0] rnd_r, rnd_nxt;
  logic [31:0]      w_r [BLK_WORDS];
  logic [31:0]      w_nxt [BLK_WORDS];
  logic [31:0]      v_r [DIGEST_WORDS];
  logic [31:0]      v_nxt [DIGEST_WORDS];
  logic [31:0]      h_r [DIGEST_WORDS];
  logic [31:0]      h_nxt [DIGEST_WORDS];
  logic [31:0]      dig_r [DIGEST_WORDS];
  logic [31:0]      dig_nxt [DIGEST_WORDS];
  logic             last_r, last_nxt;
  logic             dig_vld_r, dig_vld_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [31:0]      t1, t2, w_new;

  assign t1 = v_r[7] + bsig1(v_r[4]) + ch(v_r[4], v_r[5], v_r[6]) + ROUND_K[rnd_r] + w_r[0];
  assign t2 = bsig0(v_r[0]) + maj(v_r[0], v_r[1], v_r[2]);
  assign w_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];

  assign empty                = !dig_vld_r;
  assign out_data.digest_word = dig_r[idx_r];
  assign out_data.word_index  = idx_r;
  assign out_data.last        = (idx_r == 3'(DIGEST_WORDS - 1));

  always_comb begin
    st_nxt      = st_r;
    rnd_nxt     = rnd_r;
    w_nxt       = w_r;
    v_nxt       = v_r;
    h_nxt       = h_r;
    dig_nxt     = dig_r;
    last_nxt    = last_r;
    dig_vld_nxt = dig_vld_r;
    idx_nxt     = idx_r;
    q_pop       = 1'b0;

    if (pop && dig_vld_r) begin
      idx_nxt = idx_r + 3'd1;
      if (idx_r == 3'(DIGEST_WORDS - 1)) begin
        dig_vld_nxt = 1'b0;
      end
    end

    unique case (st_r)
      CORE_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          last_nxt = q_blk.last_blk;
          rnd_nxt  = '0;
          for (int i = 0; i < BLK_WORDS; i++) begin
            w_nxt[i] = q_blk.data[BLK_BITS-1-32*i -: 32];
          end
          v_nxt  = h_r;
          st_nxt = CORE_RUN;
        end
      end
      CORE_RUN: begin
        for (int i = 0; i < BLK_WORDS - 1; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[BLK_WORDS-1] = w_new;
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + POS_W'(1);
        if (rnd_r == POS_W'(ROUNDS - 1)) begin
          st_nxt = CORE_ADD;
        end
      end
      CORE_ADD: begin
        // A final block waits here until the previous digest is drained.
        if (!(last_r && dig_vld_r)) begin
          for (int i = 0; i < DIGEST_WORDS; i++) begin
            if (last_r) begin
              dig_nxt[i] = h_r[i] + v_r[i];
              h_nxt[i]   = H_INIT[i];
            end else begin
              h_nxt[i] = h_r[i] + v_r[i];
            end
          end
          if (last_r) begin
            dig_vld_nxt = 1'b1;
          end
          st_nxt = CORE_IDLE;
        end
      end
      default: st_nxt = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= CORE_IDLE;
      rnd_r     <= '0;
      h_r       <= H_INIT;
      dig_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      st_r      <= st_nxt;
      rnd_r     <= rnd_nxt;
      h_r       <= h_nxt;
      dig_vld_r <= dig_vld_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    v_r    <= v_nxt;
    dig_r  <= dig_nxt;
    last_r <= last_nxt;
  end

  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != CORE_RUN) |-> (rnd_r == '0))
    else $error("round counter not at zero outside a block");

  a_run_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == CORE_RUN && rnd_r == POS_W'(ROUNDS - 1)) |=> (st_r == CORE_ADD))
    else $error("last round did not lead to the feed-forward add");

  a_dig_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dig_vld_r) |-> (idx_r == '0))
    else $error("new digest does not start at word zero");

endmodule

// ===== rtl/sha256_hash_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Byte-stream SHA-256 with queue-style input and digest word output.
// ----------------------------------------------------------------------------
// Each input word carries one message byte (op = 0) or a finish command
// (op = 1). Bytes are taken one per cycle while the internal two-entry block
// queue has room. The compression core handles each complete 64-byte block
// as one load step, 64 rounds at one round per cycle and one feed-forward
// add, so for a long message the core's round loop sets the sustained byte
// rate, and full rises whenever two blocks are already waiting for it. Full
// is also high while a finish that needs an extra block hands over its
// second padded block. A finish builds one padded block, or two when more
// than 55 bytes are pending, and the digest appears once the core has run
// the last padded block through its rounds and the feed-forward add. The
// digest is then offered as eight 32-bit big-endian words, word 0 first, with
// last set on word 7, one word per pop.
// After a finish the engine returns to the initial hash and a zero count on
// its own, so the next byte starts a new message; the bit count wraps modulo
// 2^64. A further message may be absorbed while a digest still waits to be
// read; only its final block holds until the previous digest is drained.
// ----------------------------------------------------------------------------
module sha256_hash_engine_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sha_pkg::sha_in_t  in_data,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  // Block handoff between the byte collector and the compression core.
  logic     q_push, q_full, q_pop, q_empty;
  sha_blk_t q_wr_blk, q_rd_blk;

  // Front end: packs bytes and applies the padding rule.
  sha_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .q_push  (q_push),
    .q_blk   (q_wr_blk),
    .q_full  (q_full)
  );

  // Two blocks of slack so the front keeps filling while the core works.
  sha_blk_fifo u_blk_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .wr_data (q_wr_blk),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rd_data (q_rd_blk),
    .empty_o (q_empty)
  );

  // Back end: 64 rounds per block and the digest output register.
  sha_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_blk    (q_rd_blk),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
